[rtl/core/csim_pkg.sv]
// Shared widths, constants and the vector record for the cosine similarity core.
// Used by every module under rtl/core; depends on nothing.
package csim_pkg;

  localparam int SAMPLE_W  = 16;   // Q1.15 element width
  localparam int DOT_W     = 44;   // signed dot product accumulator
  localparam int NORM_W    = 43;   // unsigned squared norm accumulator
  localparam int DMAG_W    = 44;   // magnitude of the dot product
  localparam int HALF_W    = 22;   // partial product operand width
  localparam int PROD_W    = 86;   // norm_a * norm_b
  localparam int DSQ_W     = 88;   // dot magnitude squared
  localparam int FRAC_BITS = 15;
  localparam int QUO_W     = 33;   // quotient of the scaled divide, before the root
  localparam int ROOT_W    = 17;   // integer root of the quotient
  localparam int VQ_DEPTH  = 2;    // finished vectors held between front and back

  localparam logic signed [SAMPLE_W-1:0] COS_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] COS_MIN = 16'sh8000;

  // One finished vector pair, as the front hands it to the back.
  typedef struct packed {
    logic              zero;   // either norm is zero
    logic              neg;    // dot product is negative
    logic [DMAG_W-1:0] dmag;
    logic [NORM_W-1:0] norm_a;
    logic [NORM_W-1:0] norm_b;
  } vec_t;

endpackage

[rtl/core/cosine_similarity_core.sv]
// Streaming cosine similarity of two Q1.15 vectors, one element pair per item.
// Throughput: one element item per cycle while the queue is not full; the back end solves
//   one vector at a time (22x22 partial-product multiply, 33-step divide, 17-step root).
// Result: out_valid rises once the back end has solved the vector (zero norm: no solve;
//   ratio far beyond one: no divide or root), plus any wait for a back end still busy.
// Reset: synchronous active-low rst_n clears accumulators, queue and FSM; no sweep.
module cosine_similarity_core #(
  parameter int VQ_DEPTH = csim_pkg::VQ_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [csim_pkg::SAMPLE_W-1:0]  in_elem_a,
  input  logic signed [csim_pkg::SAMPLE_W-1:0]  in_elem_b,
  input  logic                                  in_last_elem,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [csim_pkg::SAMPLE_W-1:0]  out_cos_sim,
  output logic                                  out_zero_norm
);

  // Front to queue: push a finished vector on its last item.
  logic           q_push;
  logic           q_full;
  csim_pkg::vec_t q_push_data;

  // Queue to back: the back pops one vector whenever it is idle.
  logic           q_pop;
  logic           q_not_empty;
  csim_pkg::vec_t q_pop_data;

  // Accumulate dot product and both norms at full item rate; stall only
  // when the queue holds VQ_DEPTH vectors the back has not started.
  csim_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_elem_a    (in_elem_a),
    .in_elem_b    (in_elem_b),
    .in_last_elem (in_last_elem),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  // Decouple the element stream from the slow per-vector solve.
  csim_queue #(
    .DEPTH (VQ_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // |cos| = trunc(|dot| * 2^15 / sqrt(na * nb)), computed as the integer root of
  // floor(dot^2 * 2^30 / (na * nb)); hold the result until it is taken.
  csim_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_pop_data    (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cos_sim   (out_cos_sim),
    .out_zero_norm (out_zero_norm)
  );

endmodule

[rtl/core/csim_front.sv]
// Front end: accepts element pairs and accumulates dot product and squared norms.
// Depends on csim_pkg; pushes one vec_t record per vector into csim_queue.
module csim_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [csim_pkg::SAMPLE_W-1:0]   in_elem_a,
  input  logic signed [csim_pkg::SAMPLE_W-1:0]   in_elem_b,
  input  logic                                   in_last_elem,
  input  logic                                   q_full,
  output logic                                   q_push,
  output csim_pkg::vec_t                         q_push_data
);

  logic signed [csim_pkg::DOT_W-1:0]  dot_r, dot_nxt;
  logic        [csim_pkg::NORM_W-1:0] na_r, na_nxt;
  logic        [csim_pkg::NORM_W-1:0] nb_r, nb_nxt;
  logic signed [2*csim_pkg::SAMPLE_W-1:0] prod_ab, sq_a, sq_b;
  logic signed [csim_pkg::DOT_W:0]    dot_sum;
  logic        [csim_pkg::NORM_W:0]   na_sum, nb_sum;
  logic signed [csim_pkg::DOT_W-1:0]  dot_sat;
  logic        [csim_pkg::NORM_W-1:0] na_sat, nb_sat;
  logic signed [csim_pkg::DOT_W:0]    dot_neg;
  logic                               in_fire;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  assign prod_ab = in_elem_a * in_elem_b;
  assign sq_a    = in_elem_a * in_elem_a;
  assign sq_b    = in_elem_b * in_elem_b;

  assign dot_sum = (csim_pkg::DOT_W+1)'(dot_r) + (csim_pkg::DOT_W+1)'(prod_ab);
  assign na_sum  = {1'b0, na_r} + {{(csim_pkg::NORM_W-30){1'b0}}, sq_a[30:0]};
  assign nb_sum  = {1'b0, nb_r} + {{(csim_pkg::NORM_W-30){1'b0}}, sq_b[30:0]};

  // Saturate at the accumulator limits instead of wrapping.
  always_comb begin
    if (dot_sum[csim_pkg::DOT_W] != dot_sum[csim_pkg::DOT_W-1]) begin
      dot_sat = dot_sum[csim_pkg::DOT_W] ? {1'b1, {(csim_pkg::DOT_W-1){1'b0}}}
                                         : {1'b0, {(csim_pkg::DOT_W-1){1'b1}}};
    end else begin
      dot_sat = dot_sum[csim_pkg::DOT_W-1:0];
    end
    na_sat = na_sum[csim_pkg::NORM_W] ? {csim_pkg::NORM_W{1'b1}}
                                      : na_sum[csim_pkg::NORM_W-1:0];
    nb_sat = nb_sum[csim_pkg::NORM_W] ? {csim_pkg::NORM_W{1'b1}}
                                      : nb_sum[csim_pkg::NORM_W-1:0];
  end

  assign dot_neg = -(csim_pkg::DOT_W+1)'(dot_sat);

  always_comb begin
    q_push_data.zero   = (na_sat == '0) || (nb_sat == '0);
    q_push_data.neg    = dot_sat[csim_pkg::DOT_W-1];
    q_push_data.dmag   = dot_sat[csim_pkg::DOT_W-1] ? dot_neg[csim_pkg::DMAG_W-1:0]
                                                    : dot_sat;
    q_push_data.norm_a = na_sat;
    q_push_data.norm_b = nb_sat;
  end

  assign q_push = in_fire && in_last_elem;

  // Clear after the last element, otherwise keep summing.
  always_comb begin
    dot_nxt = dot_r;
    na_nxt  = na_r;
    nb_nxt  = nb_r;
    if (in_fire) begin
      if (in_last_elem) begin
        dot_nxt = '0;
        na_nxt  = '0;
        nb_nxt  = '0;
      end else begin
        dot_nxt = dot_sat;
        na_nxt  = na_sat;
        nb_nxt  = nb_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
    end else begin
      dot_r <= dot_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
    end
  end

endmodule

[rtl/core/csim_queue.sv]
// Short queue of finished vector records between front and back.
// Depends on csim_pkg for vec_t.
module csim_queue #(
  parameter int DEPTH = csim_pkg::VQ_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  csim_pkg::vec_t push_data,
  output logic           full,
  input  logic           pop,
  output csim_pkg::vec_t pop_data,
  output logic           not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csim_pkg::vec_t  mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && full |-> pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue pop while empty");

endmodule

[rtl/core/csim_back.sv]
// Back end: norm product, scaled divide and integer root for one vector at a time.
// Depends on csim_pkg; pops vec_t records from csim_queue and drives the result port.
module csim_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_not_empty,
  input  csim_pkg::vec_t                        q_pop_data,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [csim_pkg::SAMPLE_W-1:0]  out_cos_sim,
  output logic                                  out_zero_norm
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_CHK  = 6'b000100,
    S_DIV  = 6'b001000,
    S_SQRT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  localparam int DW = csim_pkg::DMAG_W;
  localparam int HW = csim_pkg::HALF_W;
  localparam int PW = csim_pkg::PROD_W;
  localparam int SW = csim_pkg::DSQ_W;
  localparam int QW = csim_pkg::QUO_W;
  localparam int RW = csim_pkg::ROOT_W;
  localparam int DIV_LOW = 2 * csim_pkg::FRAC_BITS;   // zero bits below the dividend
  localparam int DIV_SH  = QW - DIV_LOW;              // dividend bits kept for the shift-in

  state_t                               state_r, state_nxt;
  logic [5:0]                           cnt_r, cnt_nxt;
  logic                                 neg_r, neg_nxt;
  logic [DW-1:0]                        xa_r, xa_nxt, xb_r, xb_nxt, dmag_r, dmag_nxt;
  logic [SW-1:0]                        acc_r, acc_nxt, dsq_r, dsq_nxt;
  logic [PW-1:0]                        p_r, p_nxt, rem_r, rem_nxt;
  logic [QW-1:0]                        dl_r, dl_nxt, quo_r, quo_nxt;
  logic [2*RW-1:0]                      rad_r, rad_nxt;
  logic [RW+2:0]                        srem_r, srem_nxt;
  logic [RW-1:0]                        root_r, root_nxt;
  logic signed [csim_pkg::SAMPLE_W-1:0] cos_r, cos_nxt;
  logic                                 zero_r, zero_nxt;

  logic [HW-1:0]   mul_x, mul_y;
  logic [2*HW-1:0] mul_p;
  logic [SW-1:0]   mul_sh, mul_sum;
  logic [PW:0]     div_t, div_d;
  logic            div_ge;
  logic [QW-1:0]   quo_sh;
  logic [RW+2:0]   sq_r4, sq_trial, sq_d;
  logic            sq_ge;
  logic [RW-1:0]   root_sh;
  logic            sat_big;

  // 22x22 partial products; cnt_r[1:0] picks the halves, cnt_r[2] the job.
  always_comb begin
    mul_x = cnt_r[0] ? xa_r[DW-1:HW] : xa_r[HW-1:0];
    mul_y = cnt_r[1] ? xb_r[DW-1:HW] : xb_r[HW-1:0];
    mul_p = mul_x * mul_y;
    case (cnt_r[1:0])
      2'd0:    mul_sh = SW'(mul_p);
      2'd3:    mul_sh = SW'(mul_p) << (2 * HW);
      default: mul_sh = SW'(mul_p) << HW;
    endcase
    mul_sum = acc_r + mul_sh;
  end

  // Restoring divide step and root step.
  always_comb begin
    sat_big  = {1'b0, dsq_r[SW-1:DIV_SH]} >= PW'(p_r);
    div_t    = {rem_r, dl_r[QW-1]};
    div_d    = div_t - {1'b0, p_r};
    div_ge   = div_t >= {1'b0, p_r};
    quo_sh   = {quo_r[QW-2:0], div_ge};
    sq_r4    = {srem_r[RW:0], rad_r[2*RW-1:2*RW-2]};
    sq_trial = {1'b0, root_r, 2'b01};
    sq_ge    = sq_r4 >= sq_trial;
    sq_d     = sq_r4 - sq_trial;
    root_sh  = {root_r[RW-2:0], sq_ge};
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    xa_nxt    = xa_r;
    xb_nxt    = xb_r;
    dmag_nxt  = dmag_r;
    acc_nxt   = acc_r;
    dsq_nxt   = dsq_r;
    p_nxt     = p_r;
    rem_nxt   = rem_r;
    dl_nxt    = dl_r;
    quo_nxt   = quo_r;
    rad_nxt   = rad_r;
    srem_nxt  = srem_r;
    root_nxt  = root_r;
    cos_nxt   = cos_r;
    zero_nxt  = zero_r;
    q_pop     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          q_pop    = 1'b1;
          neg_nxt  = q_pop_data.neg;
          dmag_nxt = q_pop_data.dmag;
          xa_nxt   = {1'b0, q_pop_data.norm_a};
          xb_nxt   = {1'b0, q_pop_data.norm_b};
          acc_nxt  = '0;
          cnt_nxt  = '0;
          zero_nxt = q_pop_data.zero;
          cos_nxt  = '0;
          state_nxt = q_pop_data.zero ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        acc_nxt = mul_sum;
        if (cnt_r[1:0] == 2'd3) begin
          acc_nxt = '0;
          if (!cnt_r[2]) begin
            p_nxt  = mul_sum[PW-1:0];
            xa_nxt = dmag_r;
            xb_nxt = dmag_r;
          end else begin
            dsq_nxt   = mul_sum;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        // Quotient at or above 2^33 clamps anyway: skip the divide.
        if (sat_big) begin
          cos_nxt   = neg_r ? csim_pkg::COS_MIN : csim_pkg::COS_MAX;
          state_nxt = S_DONE;
        end else begin
          rem_nxt   = PW'(dsq_r[SW-1:DIV_SH]);
          dl_nxt    = {dsq_r[DIV_SH-1:0], {DIV_LOW{1'b0}}};
          quo_nxt   = '0;
          cnt_nxt   = 6'(QW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_d[PW-1:0] : div_t[PW-1:0];
        quo_nxt = quo_sh;
        dl_nxt  = {dl_r[QW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          rad_nxt   = {1'b0, quo_sh};
          srem_nxt  = '0;
          root_nxt  = '0;
          cnt_nxt   = 6'(RW - 1);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        srem_nxt = sq_ge ? sq_d : sq_r4;
        root_nxt = root_sh;
        rad_nxt  = {rad_r[2*RW-3:0], 2'b00};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (neg_r) begin
            cos_nxt = (root_sh >= RW'(32768)) ? csim_pkg::COS_MIN
                                              : -$signed(root_sh[csim_pkg::SAMPLE_W-1:0]);
          end else begin
            cos_nxt = (root_sh > RW'(32767)) ? csim_pkg::COS_MAX
                                             : $signed(root_sh[csim_pkg::SAMPLE_W-1:0]);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid     = (state_r == S_DONE);
  assign out_cos_sim   = cos_r;
  assign out_zero_norm = zero_r;

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    xa_r   <= xa_nxt;
    xb_r   <= xb_nxt;
    dmag_r <= dmag_nxt;
    acc_r  <= acc_nxt;
    dsq_r  <= dsq_nxt;
    p_r    <= p_nxt;
    rem_r  <= rem_nxt;
    dl_r   <= dl_nxt;
    quo_r  <= quo_nxt;
    rad_r  <= rad_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    cos_r  <= cos_nxt;
    zero_r <= zero_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_zero_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_norm |-> out_cos_sim == '0)
    else $error("zero norm result with nonzero cosine");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < p_r)
    else $error("divide remainder not below divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> p_r != '0)
    else $error("norm product zero on a nonzero-norm vector");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == S_MUL || state_r == S_DONE)
    else $error("pop did not start a vector");

endmodule
